>>> sv/bmba_pkg.sv
// Shared types and constants for the binary mask box average block.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package bmba_pkg;

    localparam int ROW_W      = 11;     // holds row counts up to MAX_ROWS
    localparam int MAX_ROWS   = 1024;
    localparam int FRAC_STEPS = 16;     // quotient bits below the integer bit
    localparam int SMOOTH_W   = 17;
    localparam logic [SMOOTH_W-1:0] HALF_SCALE = 17'd32768;
    localparam int APB_AW     = 4;

    // register indexes (word address paddr[3:2])
    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_WRITE,
        ST_CHECK,
        ST_START,
        ST_SUM,
        ST_FLUSH,
        ST_DIVLOAD,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic prep;
        logic write_px;
        logic check;
        logic start;
        logic issue;
        logic div_load;
        logic div_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic win_ready;
        logic last_issue;
        logic div_last;
        logic out_busy;
    } stat_t;

endpackage
`default_nettype wire

>>> sv/bmba_if.sv
// Stream channel interfaces for mask beats in and average beats out.
// Depends on bmba_pkg for the result width.
`timescale 1ns / 1ps
`default_nettype none
interface bmba_in_if;
    logic valid;
    logic ready;
    logic req_type;
    logic mask_bit;
    modport source (output valid, output req_type, output mask_bit, input ready);
    modport sink (input valid, input req_type, input mask_bit, output ready);
endinterface

interface bmba_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bmba_pkg::SMOOTH_W-1:0] smooth_value;
    logic [9:0]                           out_col;
    logic [9:0]                           out_row;
    logic                                 frame_last;
    modport source (output valid, output smooth_value, output out_col, output out_row,
                    output frame_last, input ready);
    modport sink (input valid, input smooth_value, input out_col, input out_row,
                  input frame_last, output ready);
endinterface
`default_nettype wire

>>> sv/bmba_ctrl.sv
// Sequencer for one beat: capture, store write, window check, sum, divide, emit.
// Depends on bmba_pkg (state_t, cmd_t, stat_t).
`timescale 1ns / 1ps
`default_nettype none
module bmba_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire bmba_pkg::stat_t stat,
    output bmba_pkg::cmd_t       cmd
);

    bmba_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmba_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            bmba_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = bmba_pkg::ST_PREP;
                end
            end
            bmba_pkg::ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = bmba_pkg::ST_WRITE;
            end
            bmba_pkg::ST_WRITE:
            begin
                cmd.write_px = 1'b1;
                state_next   = bmba_pkg::ST_CHECK;
            end
            bmba_pkg::ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (!stat.done && stat.win_ready)
                begin
                    state_next = bmba_pkg::ST_START;
                end
                else
                begin
                    state_next = bmba_pkg::ST_IDLE;
                end
            end
            bmba_pkg::ST_START:
            begin
                cmd.start  = 1'b1;
                state_next = bmba_pkg::ST_SUM;
            end
            bmba_pkg::ST_SUM:
            begin
                cmd.issue = 1'b1;
                if (stat.last_issue)
                begin
                    state_next = bmba_pkg::ST_FLUSH;
                end
            end
            bmba_pkg::ST_FLUSH:
            begin
                state_next = bmba_pkg::ST_DIVLOAD;
            end
            bmba_pkg::ST_DIVLOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = bmba_pkg::ST_DIV;
            end
            bmba_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = bmba_pkg::ST_EMIT;
                end
            end
            bmba_pkg::ST_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = bmba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bmba_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> sv/bmba_dp.sv
// Datapath: position counters, ring store of mask bits, window summer,
// serial divider and output register. Depends on bmba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bmba_dp #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 15
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire bmba_pkg::cmd_t                      cmd,
    output bmba_pkg::stat_t                          stat,
    input  wire logic                                restart,
    input  wire logic [$clog2(MAX_WINDOW+1)-1:0]     win_size,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]      img_w,
    input  wire logic [bmba_pkg::ROW_W-1:0]          img_h,
    input  wire logic                                req_type,
    input  wire logic                                mask_bit,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [bmba_pkg::SMOOTH_W-1:0]     smooth_value,
    output logic [9:0]                               out_col,
    output logic [9:0]                               out_row,
    output logic                                     frame_last
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int NW    = 2 * WIN_W;
    localparam int RW    = bmba_pkg::ROW_W;
    localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = AW + WIN_W + WW + 2;
    localparam int XW    = ((WW > WIN_W) ? WW : WIN_W) + 1;
    localparam int QL    = bmba_pkg::FRAC_STEPS;
    localparam int SCW   = $clog2(QL);

    // captured beat
    logic pix_reg, mask_reg;

    // frame position state
    logic [WW-1:0] in_col_reg, emit_col_reg;
    logic [RW-1:0] in_row_reg, emit_row_reg;
    logic          in_full_reg, emit_done_reg;
    logic [AW-1:0] wr_addr_reg, emit_addr_reg;

    // window walk
    logic [RW-1:0]    y0_reg, y1_reg, y_reg;
    logic [WW-1:0]    x0_reg, x1_reg, x_reg;
    logic [WIN_W-1:0] dyoff_reg, dxoff_reg;
    logic [AW-1:0]    row_start_reg, cur_addr_reg;
    logic             rd_bit_reg, rd_vld_reg;
    logic [NW-1:0]    count_reg;

    // divider
    logic          q_hi_reg;
    logic [QL-1:0] q_lo_reg;
    logic [NW-1:0] rem_reg;
    logic [SCW-1:0] div_cnt_reg;

    logic mem [DEPTH];

    // ---------------- combinational helpers ----------------
    logic [WIN_W-1:0] hw;
    logic [RW:0]      ry_sum, h_last;
    logic [RW-1:0]    y0_c, y1_c;
    logic [XW-1:0]    ec_e, hw_x, x0_e, x1_e, xs_e, w_last;
    logic [WW-1:0]    x1_c;
    logic             win_ready;
    logic             frame_restart;
    logic             last_px;

    assign hw     = win_size >> 1;
    assign ry_sum = {1'b0, emit_row_reg} + (RW+1)'(hw);
    assign h_last = (RW+1)'(img_h) - (RW+1)'(1);
    assign y1_c   = (ry_sum > h_last) ? RW'(h_last) : RW'(ry_sum);
    assign y0_c   = (emit_row_reg >= RW'(hw)) ? (emit_row_reg - RW'(hw)) : '0;

    assign ec_e   = XW'(emit_col_reg);
    assign hw_x   = XW'(hw);
    assign w_last = XW'(img_w) - XW'(1);
    assign xs_e   = ec_e + hw_x;
    assign x0_e   = (ec_e >= hw_x) ? (ec_e - hw_x) : '0;
    assign x1_e   = (xs_e > w_last) ? w_last : xs_e;
    assign x1_c   = WW'(x1_e);

    // raster order compare of the window's last pixel against the write point
    assign win_ready = in_full_reg || (y1_c < in_row_reg) ||
                       ((y1_c == in_row_reg) && (x1_c < in_col_reg));

    assign frame_restart = restart ||
                           (cmd.prep && pix_reg && in_full_reg && emit_done_reg);

    assign last_px = (emit_row_reg == (img_h - RW'(1))) &&
                     (emit_col_reg == (img_w - WW'(1)));

    // window start address: emit address minus row and column offsets, ring wrap
    logic [WIN_W+WW-1:0] row_off;
    logic [LW-1:0]       off_l, ea_l, rs_l;
    assign row_off = dyoff_reg * img_w;
    assign off_l   = LW'(row_off) + LW'(dxoff_reg);
    assign ea_l    = LW'(emit_addr_reg);
    assign rs_l    = (ea_l >= off_l) ? (ea_l - off_l) : (ea_l + LW'(DEPTH) - off_l);

    logic [LW-1:0] rn_l;
    logic [AW-1:0] row_next;
    assign rn_l     = LW'(row_start_reg) + LW'(img_w);
    assign row_next = (rn_l >= LW'(DEPTH)) ? AW'(rn_l - LW'(DEPTH)) : AW'(rn_l);

    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        addr_inc = (a == AW'(DEPTH - 1)) ? '0 : (a + AW'(1));
    endfunction

    logic last_issue;
    assign last_issue = (x_reg == x1_reg) && (y_reg == y1_reg);

    logic [NW-1:0] n_val;
    logic [NW:0]   r2;
    logic          r2_ge;
    assign n_val = win_size * win_size;
    assign r2    = {rem_reg, 1'b0};
    assign r2_ge = (r2 >= {1'b0, n_val});

    logic out_busy;
    assign out_busy = out_valid & ~out_ready;

    always_comb
    begin
        stat            = '0;
        stat.done       = emit_done_reg;
        stat.win_ready  = win_ready;
        stat.last_issue = last_issue;
        stat.div_last   = (div_cnt_reg == SCW'(QL - 1));
        stat.out_busy   = out_busy;
    end

    // ---------------- beat capture ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pix_reg  <= ~req_type;
            mask_reg <= mask_bit;
        end
    end

    // ---------------- position counters ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_full_reg   <= 1'b0;
            wr_addr_reg   <= '0;
            emit_col_reg  <= '0;
            emit_row_reg  <= '0;
            emit_done_reg <= 1'b0;
            emit_addr_reg <= '0;
        end
        else if (frame_restart)
        begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_full_reg   <= 1'b0;
            wr_addr_reg   <= '0;
            emit_col_reg  <= '0;
            emit_row_reg  <= '0;
            emit_done_reg <= 1'b0;
            emit_addr_reg <= '0;
        end
        else
        begin
            if (cmd.write_px && pix_reg && !in_full_reg)
            begin
                wr_addr_reg <= addr_inc(wr_addr_reg);
                if (({1'b0, in_col_reg} + (WW+1)'(1)) >= (WW+1)'(img_w))
                begin
                    in_col_reg <= '0;
                    if (({1'b0, in_row_reg} + (RW+1)'(1)) >= (RW+1)'(img_h))
                    begin
                        in_full_reg <= 1'b1;
                    end
                    else
                    begin
                        in_row_reg <= in_row_reg + RW'(1);
                    end
                end
                else
                begin
                    in_col_reg <= in_col_reg + WW'(1);
                end
            end
            if (cmd.emit)
            begin
                emit_addr_reg <= addr_inc(emit_addr_reg);
                if (last_px)
                begin
                    emit_done_reg <= 1'b1;
                end
                else if (({1'b0, emit_col_reg} + (WW+1)'(1)) >= (WW+1)'(img_w))
                begin
                    emit_col_reg <= '0;
                    emit_row_reg <= emit_row_reg + RW'(1);
                end
                else
                begin
                    emit_col_reg <= emit_col_reg + WW'(1);
                end
            end
        end
    end

    // ---------------- mask ring store ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.write_px && pix_reg && !in_full_reg)
        begin
            mem[wr_addr_reg] <= mask_reg;
        end
        rd_bit_reg <= mem[cur_addr_reg];
    end

    // ---------------- window walk and count ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            y0_reg    <= y0_c;
            y1_reg    <= y1_c;
            x0_reg    <= WW'(x0_e);
            x1_reg    <= x1_c;
            dyoff_reg <= WIN_W'(emit_row_reg - y0_c);
            dxoff_reg <= WIN_W'(ec_e - x0_e);
        end
        if (cmd.start)
        begin
            row_start_reg <= AW'(rs_l);
            cur_addr_reg  <= AW'(rs_l);
            y_reg         <= y0_reg;
            x_reg         <= x0_reg;
        end
        else if (cmd.issue)
        begin
            if (x_reg == x1_reg)
            begin
                y_reg         <= y_reg + RW'(1);
                x_reg         <= x0_reg;
                row_start_reg <= row_next;
                cur_addr_reg  <= row_next;
            end
            else
            begin
                x_reg        <= x_reg + WW'(1);
                cur_addr_reg <= addr_inc(cur_addr_reg);
            end
        end
        if (cmd.start)
        begin
            count_reg <= '0;
        end
        else if (rd_vld_reg && rd_bit_reg)
        begin
            count_reg <= count_reg + NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.issue;
        end
    end

    // ---------------- serial divider: floor(count * 2^16 / N) ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            div_cnt_reg <= '0;
            q_lo_reg    <= '0;
            if (count_reg >= n_val)
            begin
                q_hi_reg <= 1'b1;
                rem_reg  <= count_reg - n_val;
            end
            else
            begin
                q_hi_reg <= 1'b0;
                rem_reg  <= count_reg;
            end
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + SCW'(1);
            q_lo_reg    <= {q_lo_reg[QL-2:0], r2_ge};
            rem_reg     <= r2_ge ? NW'(r2 - {1'b0, n_val}) : NW'(r2);
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            smooth_value <= $signed({q_hi_reg, q_lo_reg} - bmba_pkg::HALF_SCALE);
            out_col      <= 10'(emit_col_reg);
            out_row      <= 10'(emit_row_reg);
            frame_last   <= last_px;
        end
    end

endmodule
`default_nettype wire

>>> sv/binary_mask_box_average_top.sv
// Top level of the binary mask box average: APB register file, effective
// configuration, and the controller/datapath pair. Depends on bmba_pkg, bmba_if.
`timescale 1ns / 1ps
`default_nettype none
// Mask beats (req_type 0) arrive in raster order; for every pixel the block
// counts set bits in a centered odd window, clipped at the image edges, and
// returns floor(count*65536/N) - 32768 with N the full window area, i.e. the
// signed average in 15 fraction bits. Results leave in raster order as soon
// as the window's last pixel is in; drain beats (req_type 1) flush the rest,
// one per beat. Beats are handled one at a time. A beat that yields a result
// walks the clipped window, reading its in-image pixels (at most N) from the
// ring store one bit per cycle, then runs the bit-serial divider. The store
// needs no clearing pass after reset: every entry is written before it is read.
// A write to one of the three registers restarts the frame; the store keeps
// its contents. Registers: window size at 0x0 (even values are rounded up,
// large values clamped), width at 0x4, height at 0x8.
module binary_mask_box_average_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 15
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bmba_pkg::APB_AW-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    bmba_in_if.sink                            in_ch,
    bmba_out_if.source                         out_ch
);

    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
    localparam int RW      = bmba_pkg::ROW_W;
    localparam int WIN_TOP = (MAX_WINDOW - 1) | 1;

    // APB registers, raw values as written
    logic [3:0]  window_size_reg;
    logic [10:0] image_width_reg;
    logic [10:0] image_height_reg;

    logic       wr_en;
    logic       cfg_restart;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg  <= 4'd3;
            image_width_reg  <= 11'd1024;
            image_height_reg <= 11'd1024;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                bmba_pkg::REG_WINDOW: window_size_reg  <= pwdata[3:0];
                bmba_pkg::REG_WIDTH:  image_width_reg  <= pwdata[10:0];
                bmba_pkg::REG_HEIGHT: image_height_reg <= pwdata[10:0];
                default:              ;
            endcase
        end
    end

    // a write to a real register restarts the frame; others are dropped
    always_comb
    begin
        unique case (reg_idx)
            bmba_pkg::REG_WINDOW: cfg_restart = wr_en;
            bmba_pkg::REG_WIDTH:  cfg_restart = wr_en;
            bmba_pkg::REG_HEIGHT: cfg_restart = wr_en;
            default:              cfg_restart = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (reg_idx)
            bmba_pkg::REG_WINDOW: prdata = {28'd0, window_size_reg};
            bmba_pkg::REG_WIDTH:  prdata = {21'd0, image_width_reg};
            bmba_pkg::REG_HEIGHT: prdata = {21'd0, image_height_reg};
            default:              prdata = '0;
        endcase
    end

    // effective configuration: odd window within bounds, width/height >= 1
    logic [3:0]       win_odd;
    logic [WIN_W-1:0] eff_win;
    logic [WW-1:0]    eff_w;
    logic [RW-1:0]    eff_h;

    assign win_odd = window_size_reg | 4'd1;
    assign eff_win = (int'(win_odd) > WIN_TOP) ? WIN_W'(WIN_TOP) : WIN_W'(win_odd);

    always_comb
    begin
        priority if (image_width_reg == 11'd0)
        begin
            eff_w = WW'(1);
        end
        else if (int'(image_width_reg) > MAX_WIDTH)
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(image_width_reg);
        end
    end

    always_comb
    begin
        priority if (image_height_reg == 11'd0)
        begin
            eff_h = RW'(1);
        end
        else if (int'(image_height_reg) > bmba_pkg::MAX_ROWS)
        begin
            eff_h = RW'(bmba_pkg::MAX_ROWS);
        end
        else
        begin
            eff_h = RW'(image_height_reg);
        end
    end

    bmba_pkg::cmd_t  cmd;
    bmba_pkg::stat_t stat;

    bmba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bmba_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .restart      (cfg_restart),
        .win_size     (eff_win),
        .img_w        (eff_w),
        .img_h        (eff_h),
        .req_type     (in_ch.req_type),
        .mask_bit     (in_ch.mask_bit),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .smooth_value (out_ch.smooth_value),
        .out_col      (out_ch.out_col),
        .out_row      (out_ch.out_row),
        .frame_last   (out_ch.frame_last)
    );

endmodule
`default_nettype wire

>>> verif/binary_mask_box_average_top_tb.sv
// Self-checking bench for binary_mask_box_average_top: random mask frames, drain
// beats and register changes, checked against an in-bench window-average predictor.
// Depends on bmba_pkg, bmba_if and the block's RTL.
`timescale 1ns / 1ps

typedef struct packed {
    logic signed [bmba_pkg::SMOOTH_W-1:0] avg;
    logic [9:0]                           col;
    logic [9:0]                           row;
    logic                                 last;
} avg_beat_t;

// Predicts the averages from the accepted beats and checks the returned ones.
class mask_avg_board;
    localparam int STORE_DEPTH = 15 * 1024;

    bit [3:0]    win_reg;
    bit [10:0]   width_reg;
    bit [10:0]   height_reg;
    bit          mask_ring [STORE_DEPTH];
    int unsigned px_col, px_row, res_col, res_row;
    bit          input_full, emit_done;
    avg_beat_t   expected_q[$];
    int          errors;

    function new();
        win_reg    = 4'd3;
        width_reg  = 11'd1024;
        height_reg = 11'd1024;
        errors     = 0;
        restart();
    endfunction

    function void restart();
        px_col = 0; px_row = 0; res_col = 0; res_row = 0;
        input_full = 0; emit_done = 0;
    endfunction

    function void set_reg(int idx, bit [31:0] val);
        case (idx)
            int'(bmba_pkg::REG_WINDOW): win_reg    = val[3:0];
            int'(bmba_pkg::REG_WIDTH):  width_reg  = val[10:0];
            int'(bmba_pkg::REG_HEIGHT): height_reg = val[10:0];
            default: return;
        endcase
        restart();
    endfunction

    function bit frame_done();
        return input_full && emit_done;
    endfunction

    // Note an accepted input beat and queue the result it causes, if any.
    function void note_input(bit drain, bit mask);
        int unsigned w, h, s, hw, n, got, ry, rx, cnt, v;
        int          y, x;
        avg_beat_t   e;
        w = (width_reg == 0) ? 1 : (width_reg > 1024 ? 1024 : width_reg);
        h = (height_reg == 0) ? 1 : (height_reg > 1024 ? 1024 : height_reg);
        s = win_reg | 1;
        if (s > 15) s = 15;
        hw = s / 2;
        n = s * s;
        if (!drain && input_full && emit_done) restart();
        if (!drain && !input_full) begin
            mask_ring[(px_row * w + px_col) % STORE_DEPTH] = mask;
            if (px_col + 1 >= w) begin
                px_col = 0;
                if (px_row + 1 >= h) input_full = 1;
                else px_row++;
            end
            else px_col++;
        end
        if (emit_done) return;
        got = input_full ? h * w : px_row * w + px_col;
        ry = res_row + hw;
        rx = res_col + hw;
        if (ry > h - 1) ry = h - 1;
        if (rx > w - 1) rx = w - 1;
        if (ry * w + rx >= got) return;
        cnt = 0;
        for (y = int'(res_row) - int'(hw); y <= int'(res_row) + int'(hw); y++)
            for (x = int'(res_col) - int'(hw); x <= int'(res_col) + int'(hw); x++)
                if (y >= 0 && y < int'(h) && x >= 0 && x < int'(w))
                    cnt += mask_ring[(y * w + x) % STORE_DEPTH];
        v = (cnt * 65536) / n - 32768;
        e.avg  = v[bmba_pkg::SMOOTH_W-1:0];
        e.col  = res_col[9:0];
        e.row  = res_row[9:0];
        e.last = (res_row == h - 1) && (res_col == w - 1);
        expected_q.insert(expected_q.size(), e);
        if (e.last) emit_done = 1;
        else if (res_col + 1 >= w) begin
            res_col = 0;
            res_row++;
        end
        else res_col++;
    endfunction

    function void check_result(avg_beat_t got);
        avg_beat_t e;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, actual %p", $time, got);
            errors++;
            return;
        end
        e = expected_q[0];
        expected_q.delete(0);
        if (got.avg !== e.avg) begin
            $display("%0t: smooth_value expected %0d actual %0d", $time, e.avg, got.avg);
            errors++;
        end
        if (got.col !== e.col) begin
            $display("%0t: out_col expected %0d actual %0d", $time, e.col, got.col);
            errors++;
        end
        if (got.row !== e.row) begin
            $display("%0t: out_row expected %0d actual %0d", $time, e.row, got.row);
            errors++;
        end
        if (got.last !== e.last) begin
            $display("%0t: frame_last expected %0d actual %0d", $time, e.last, got.last);
            errors++;
        end
    endfunction
endclass

module binary_mask_box_average_top_tb;

    // Watchdog bound; beats plus stalls stay well under this.
    localparam int CYCLE_LIMIT = 6_000_000;
    // Settle time before a register write or the final verdict.
    localparam int SETTLE      = 300;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [bmba_pkg::APB_AW-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    bmba_in_if  in_ch ();
    bmba_out_if out_ch ();

    binary_mask_box_average_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    mask_avg_board board;
    int            beats_sent;
    int            cycle_count;
    bit            no_gaps;     // set for stretches with no idling on either side
    avg_beat_t     got;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // Timeout watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random back-pressure, check every accepted beat.
    int stall_left;
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.avg  = out_ch.smooth_value;
            got.col  = out_ch.out_col;
            got.row  = out_ch.out_row;
            got.last = out_ch.frame_last;
            board.check_result(got);
        end
        if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else begin
            stall_left   <= pick_gap();
            out_ch.ready <= 1'b1;
        end
    end

    // One input beat; valid stays high across back-to-back beats.
    task automatic send_beat(bit drain, bit mask);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.req_type <= drain;
        in_ch.mask_bit <= mask;
        do @(posedge clk); while (!in_ch.ready);
        board.note_input(drain, mask);
        beats_sent++;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Setup then access cycle; the write lands on the access edge.
    task automatic reg_write(logic [1:0] idx, bit [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_reg(int'(idx), val);
    endtask

    task automatic configure(bit [31:0] win, bit [31:0] w, bit [31:0] h);
        wait_idle();
        reg_write(bmba_pkg::REG_WINDOW, win);
        reg_write(bmba_pkg::REG_WIDTH, w);
        reg_write(bmba_pkg::REG_HEIGHT, h);
    endtask

    // Whole frame: pixels at the given density, then drains until all out.
    // Noise adds early drains, dropped pixels after the frame and late drains.
    task automatic run_frame(int density, bit noise);
        int w, h, i;
        w = (board.width_reg == 0) ? 1 : (board.width_reg > 1024 ? 1024 : board.width_reg);
        h = (board.height_reg == 0) ? 1 : (board.height_reg > 1024 ? 1024 : board.height_reg);
        for (i = 0; i < w * h; i++) begin
            if (noise && $urandom_range(0, 19) == 0) send_beat(1'b1, $urandom_range(0, 1));
            send_beat(1'b0, $urandom_range(0, 99) < density);
        end
        while (!board.frame_done()) begin
            if (noise && $urandom_range(0, 3) == 0) send_beat(1'b0, $urandom_range(0, 1));
            else send_beat(1'b1, $urandom_range(0, 1));
        end
        if (noise && $urandom_range(0, 1) == 1) send_beat(1'b1, $urandom_range(0, 1));
    endtask

    initial
    begin
        int pass_no, density;
        board          = new();
        beats_sent     = 0;
        cycle_count    = 0;
        stall_left     = 0;
        no_gaps        = 0;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_ch.valid    = 1'b0;
        in_ch.req_type = 1'b0;
        in_ch.mask_bit = 1'b0;
        out_ch.ready   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full-scale averages, size rounding and clamping.
        configure(32'd0, 32'd2, 32'd2);        // zero window -> 1
        run_frame(100, 0);                     // +1.0 everywhere
        run_frame(0, 0);                       // -1.0, new frame started by a pixel
        configure(32'd2, 32'd0, 32'd3);        // even window -> 3, zero width -> 1
        run_frame(50, 1);
        configure(32'd15, 32'd3, 32'd0);       // largest window, zero height
        send_beat(1'b1, 1'b1);                 // drain before any pixel: no result
        run_frame(50, 1);
        send_beat(1'b1, 1'b0);                 // drain after the frame: no result

        // Wide and tall extremes (effective sizes clamp at 1024).
        configure(32'd15, 32'd2047, 32'd1);
        run_frame(50, 0);
        configure(32'd7, 32'd1, 32'd2047);
        run_frame(50, 0);

        // Random frames, mostly small; some reuse the current setup.
        pass_no = 0;
        while (pass_no == 0 || beats_sent < 2000) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            if (pass_no == 0 || $urandom_range(0, 3) != 0)
                configure($urandom_range(0, 15),
                          ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16),
                          ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12));
            density = $urandom_range(0, 100);
            if (pass_no == 0) begin
                // Hold off mid-frame until everything owed so far is out.
                send_beat(1'b0, 1'b1);
                wait_idle();
            end
            run_frame(density, $urandom_range(0, 2) == 0);
            pass_no++;
        end

        no_gaps = 0;
        wait_idle();
        if (board.errors == 0 && board.expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
